// ===== sv/cprs_pkg.sv =====
// ----------------------------------------------------------------------------
// cprs_pkg
// Types, constants and lookup tables for the configuration port register
// readback sequencer.
// ----------------------------------------------------------------------------
package cprs_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned INDEX_W    = 5;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned CMD_CNT_W  = 4;
    localparam int unsigned DSY_CNT_W  = 3;
    localparam int unsigned RX_CNT_W   = 3;

    localparam logic [INDEX_W-1:0]   TABLE_SIZE  = 5'd20;
    localparam logic [CMD_CNT_W-1:0] CMD_WORDS   = 4'd9;
    localparam logic [CMD_CNT_W-1:0] HEADER_SLOT = 4'd6;
    localparam logic [DSY_CNT_W-1:0] DSY_WORDS   = 3'd4;
    localparam logic [RX_CNT_W-1:0]  RX_SAT      = 3'd6;
    localparam logic [RX_CNT_W-1:0]  SKIP_LIMIT  = 3'd5;
    localparam int unsigned          ADDR_SHIFT  = 13;

    localparam logic [WORD_W-1:0] READ_HEADER = 32'h2800_0001;
    localparam logic [WORD_W-1:0] JUNK_D9     = 32'hFFFF_FFD9;
    localparam logic [WORD_W-1:0] JUNK_DB     = 32'hFFFF_FFDB;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SEND     = 3'd1,
        PH_TO_READ  = 3'd2,
        PH_READ     = 3'd3,
        PH_TO_WRITE = 3'd4,
        PH_DESYNC   = 3'd5
    } t_phase;

    // sequencer state carried between the register file and the step logic
    typedef struct packed {
        t_phase                phase;
        logic [ADDR_W-1:0]     addr;
        logic [CMD_CNT_W-1:0]  cmd_cnt;
        logic [DSY_CNT_W-1:0]  dsy_cnt;
        logic [RX_CNT_W-1:0]   rx_cnt;
        logic                  cs_lvl;
        logic                  dir_lvl;
    } t_seq_state;

    // one result item
    typedef struct packed {
        logic              chip_select_n;
        logic              read_not_write;
        logic              tx_valid;
        logic [WORD_W-1:0] tx_word;
        logic              rx_accept;
        logic              reg_valid;
        logic [WORD_W-1:0] reg_value;
        logic              done_res;
    } t_result;

    // register table index to port register address
    function automatic logic [ADDR_W-1:0] reg_addr(input logic [INDEX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            5'd15:   a = 5'd16;
            5'd16:   a = 5'd17;
            5'd17:   a = 5'd22;
            5'd18:   a = 5'd24;
            5'd19:   a = 5'd31;
            default: a = idx;
        endcase
        return a;
    endfunction

    // registers that cannot be read back
    function automatic logic reg_write_only(input logic [INDEX_W-1:0] idx);
        logic w;
        case (idx)
            5'd2, 5'd8, 5'd10, 5'd11: w = 1'b1;
            default:                  w = 1'b0;
        endcase
        return w;
    endfunction

    // sync and command words around the read header, which goes in HEADER_SLOT
    function automatic logic [WORD_W-1:0] sync_word(input logic [CMD_CNT_W-1:0] n);
        logic [WORD_W-1:0] w;
        case (n)
            4'd0:    w = 32'hFFFF_FFFF;
            4'd1:    w = 32'h0000_00BB;
            4'd2:    w = 32'h1122_0044;
            4'd3:    w = 32'hFFFF_FFFF;
            4'd4:    w = 32'hAA99_5566;
            4'd5:    w = 32'h2000_0000;
            4'd7:    w = 32'h2000_0000;
            4'd8:    w = 32'h2000_0000;
            default: w = '0;
        endcase
        return w;
    endfunction

    // desync words after the readback
    function automatic logic [WORD_W-1:0] desync_word(input logic [1:0] n);
        logic [WORD_W-1:0] w;
        case (n)
            2'd0:    w = 32'h3000_8001;
            2'd1:    w = 32'h0000_000D;
            default: w = 32'h2000_0000;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/cprs_step.sv =====
// ----------------------------------------------------------------------------
// cprs_step
// One protocol step: next sequencer state and the result item for one
// input item, computed from the current state.
// ----------------------------------------------------------------------------
module cprs_step (
    input  cprs_pkg::t_seq_state          i_state,
    input  logic [cprs_pkg::INDEX_W-1:0]  i_reg_index,
    input  logic                          i_rx_valid,
    input  logic [cprs_pkg::WORD_W-1:0]   i_rx_word,
    output cprs_pkg::t_seq_state          o_state,
    output cprs_pkg::t_result             o_result
);
    import cprs_pkg::*;

    logic                 reject;
    logic                 junk;
    logic [RX_CNT_W-1:0]  rx_cnt_inc;
    logic                 word_taken;
    logic [WORD_W-1:0]    header;
    t_seq_state           n_state;

    // request check and read-phase word qualification
    assign reject     = (i_reg_index >= TABLE_SIZE) || reg_write_only(i_reg_index);
    assign junk       = (i_rx_word == '0) || (i_rx_word == JUNK_D9)
                        || (i_rx_word == JUNK_DB);
    assign rx_cnt_inc = (i_state.rx_cnt < RX_SAT) ? i_state.rx_cnt + 1'b1
                                                  : i_state.rx_cnt;
    assign word_taken = i_rx_valid && !(junk && (rx_cnt_inc <= SKIP_LIMIT));
    assign header     = READ_HEADER
                        | (WORD_W'(i_state.addr) << ADDR_SHIFT);

    // next state
    always_comb begin
        n_state = i_state;
        if (!reject) begin
            case (i_state.phase)
                PH_IDLE: begin
                    n_state.cmd_cnt = '0;
                    n_state.dsy_cnt = '0;
                    n_state.rx_cnt  = '0;
                    n_state.addr    = reg_addr(i_reg_index);
                    n_state.cs_lvl  = 1'b1;
                    n_state.dir_lvl = 1'b0;
                    n_state.phase   = PH_SEND;
                end
                PH_SEND: begin
                    n_state.dir_lvl = 1'b0;
                    if (i_state.cmd_cnt < CMD_WORDS) begin
                        n_state.cs_lvl  = 1'b0;
                        n_state.cmd_cnt = i_state.cmd_cnt + 1'b1;
                    end else begin
                        n_state.cs_lvl = 1'b1;
                        n_state.phase  = PH_TO_READ;
                    end
                end
                PH_TO_READ: begin
                    n_state.cs_lvl  = 1'b1;
                    n_state.dir_lvl = 1'b1;
                    n_state.phase   = PH_READ;
                end
                PH_READ: begin
                    n_state.cs_lvl  = 1'b0;
                    n_state.dir_lvl = 1'b1;
                    if (i_rx_valid) begin
                        n_state.rx_cnt = rx_cnt_inc;
                    end
                    if (word_taken) begin
                        n_state.phase = PH_TO_WRITE;
                    end
                end
                PH_TO_WRITE: begin
                    n_state.cs_lvl  = 1'b1;
                    n_state.dir_lvl = 1'b1;
                    n_state.phase   = PH_DESYNC;
                end
                PH_DESYNC: begin
                    if (i_state.dsy_cnt < DSY_WORDS) begin
                        n_state.cs_lvl  = 1'b0;
                        n_state.dir_lvl = 1'b0;
                        n_state.dsy_cnt = i_state.dsy_cnt + 1'b1;
                    end else begin
                        n_state.cs_lvl  = 1'b1;
                        n_state.dir_lvl = 1'b1;
                        n_state.phase   = PH_IDLE;
                    end
                end
                default: begin
                    n_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_state = n_state;

    // result item
    always_comb begin
        o_result                = '0;
        o_result.chip_select_n  = n_state.cs_lvl;
        o_result.read_not_write = n_state.dir_lvl;
        if (reject) begin
            o_result.done_res = 1'b1;
        end else begin
            case (i_state.phase)
                PH_SEND: begin
                    if (i_state.cmd_cnt < CMD_WORDS) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_word  = (i_state.cmd_cnt == HEADER_SLOT)
                                            ? header : sync_word(i_state.cmd_cnt);
                    end
                end
                PH_READ: begin
                    o_result.rx_accept = i_rx_valid;
                    if (word_taken) begin
                        o_result.reg_valid = 1'b1;
                        o_result.reg_value = i_rx_word;
                    end
                end
                PH_DESYNC: begin
                    if (i_state.dsy_cnt < DSY_WORDS) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_word  = desync_word(i_state.dsy_cnt[1:0]);
                    end else begin
                        o_result.done_res = 1'b1;
                    end
                end
                default: begin
                    o_result.tx_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== sv/config_port_register_readback_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// config_port_register_readback_sequencer_top
// Register readback sequencer for a configuration port: one protocol step
// per transfer, result held in an output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | i_valid / o_stall  | reg_index, rx_valid, rx_word
//  out     | output    | o_valid / i_stall  | chip_select_n, read_not_write,
//          |           |                    | tx_valid, tx_word, rx_accept,
//          |           |                    | reg_valid, reg_value, done_res
//
// Each input transfer gives one result in the cycle after; a new transfer is
// taken every cycle while the output register is empty or being drained.
// The step logic between the state and output registers is combinational.
// Synchronous active-low reset puts the sequencer in idle, port deselected,
// direction read, output register empty.
// A stall on the output holds the result and raises o_stall on the input.
// ----------------------------------------------------------------------------
module config_port_register_readback_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cprs_pkg::INDEX_W-1:0]  i_reg_index,
    input  logic                          i_rx_valid,
    input  logic [cprs_pkg::WORD_W-1:0]   i_rx_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_chip_select_n,
    output logic                          o_read_not_write,
    output logic                          o_tx_valid,
    output logic [cprs_pkg::WORD_W-1:0]   o_tx_word,
    output logic                          o_rx_accept,
    output logic                          o_reg_valid,
    output logic [cprs_pkg::WORD_W-1:0]   o_reg_value,
    output logic                          o_done_res
);
    import cprs_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       in_xfer;

    // input transfer whenever the output register can take a result
    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    // step logic
    cprs_step u_step (
        .i_state     (r_state),
        .i_reg_index (i_reg_index),
        .i_rx_valid  (i_rx_valid),
        .i_rx_word   (i_rx_word),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_IDLE;
            r_state.addr    <= '0;
            r_state.cmd_cnt <= '0;
            r_state.dsy_cnt <= '0;
            r_state.rx_cnt  <= '0;
            r_state.cs_lvl  <= 1'b1;
            r_state.dir_lvl <= 1'b1;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_chip_select_n  = r_result.chip_select_n;
    assign o_read_not_write = r_result.read_not_write;
    assign o_tx_valid       = r_result.tx_valid;
    assign o_tx_word        = r_result.tx_word;
    assign o_rx_accept      = r_result.rx_accept;
    assign o_reg_valid      = r_result.reg_valid;
    assign o_reg_value      = r_result.reg_value;
    assign o_done_res       = r_result.done_res;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the register readback sequencer. Each input
// transfer is one protocol step; an internal predictor steps its own copy of
// the sequencer for every accepted transfer and queues the expected result,
// which the monitor compares with each result. Stimulus is mostly complete
// readback sequences with random port traffic, mixed with rejected indexes.
// ----------------------------------------------------------------------------
module tb;

    import cprs_pkg::*;

    localparam int unsigned NUM_ITEMS  = 1050;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_AT    = 250;  // result count that starts the long hold
    localparam int unsigned LONG_HOLD  = 60;
    localparam int unsigned DRAIN_AT   = 600;  // item that waits for an empty scoreboard
    localparam int unsigned SETTLE     = 4;

    // own copies of the lookup tables
    localparam logic [ADDR_W-1:0] ADDR_MAP [0:19] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd16, 5'd17, 5'd22, 5'd24, 5'd31
    };
    localparam logic [19:0] WRITE_ONLY = 20'h00D04;   // indexes 2, 8, 10, 11
    localparam logic [WORD_W-1:0] SYNC_SEQ [0:8] = '{
        32'hFFFF_FFFF, 32'h0000_00BB, 32'h1122_0044, 32'hFFFF_FFFF, 32'hAA99_5566,
        32'h2000_0000, 32'h0000_0000, 32'h2000_0000, 32'h2000_0000
    };
    localparam logic [WORD_W-1:0] DESYNC_SEQ [0:3] = '{
        32'h3000_8001, 32'h0000_000D, 32'h2000_0000, 32'h2000_0000
    };

    typedef struct {
        logic [INDEX_W-1:0] reg_index;
        logic               rx_valid;
        logic [WORD_W-1:0]  rx_word;
        int unsigned        gap;
        bit                 drain_first;
    } t_step_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [INDEX_W-1:0]   i_reg_index = '0;
    logic                 i_rx_valid = 1'b0;
    logic [WORD_W-1:0]    i_rx_word = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_chip_select_n;
    logic                 o_read_not_write;
    logic                 o_tx_valid;
    logic [WORD_W-1:0]    o_tx_word;
    logic                 o_rx_accept;
    logic                 o_reg_valid;
    logic [WORD_W-1:0]    o_reg_value;
    logic                 o_done_res;

    t_step_item   pend_q[$];
    t_result      expect_q[$];
    t_seq_state   plan_st;      // generation-time copy, steers the stimulus
    t_seq_state   seq_st;       // copy advanced on accepted transfers
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int unsigned  sent_cnt = 0;
    int unsigned  res_cnt = 0;
    int unsigned  mismatch_cnt = 0;
    int unsigned  read_cnt = 0;
    int unsigned  reject_cnt = 0;
    int unsigned  drop_cnt = 0;
    int unsigned  stall_left = 0;
    int unsigned  idle_cycles = 0;

    config_port_register_readback_sequencer_top dut (.*);

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_seq_state reset_state();
        t_seq_state s;
        s = '0;
        s.phase   = PH_IDLE;
        s.cs_lvl  = 1'b1;
        s.dir_lvl = 1'b1;
        return s;
    endfunction

    function automatic bit is_readable(input logic [INDEX_W-1:0] idx);
        return idx < TABLE_SIZE && !WRITE_ONLY[idx];
    endfunction

    // one sequencer step: next state and the result it shows
    function automatic void step_readback(input t_seq_state s, input t_step_item it,
                                          output t_seq_state n, output t_result r);
        logic             junk;
        logic [RX_CNT_W-1:0] cnt;
        n = s;
        r = '0;
        if (!is_readable(it.reg_index)) begin
            r.done_res = 1'b1;
        end else begin
            case (s.phase)
                PH_IDLE: begin
                    n.cmd_cnt = '0;
                    n.dsy_cnt = '0;
                    n.rx_cnt  = '0;
                    n.addr    = ADDR_MAP[it.reg_index];
                    n.cs_lvl  = 1'b1;
                    n.dir_lvl = 1'b0;
                    n.phase   = PH_SEND;
                end
                PH_SEND: begin
                    if (s.cmd_cnt < CMD_WORDS) begin
                        n.cs_lvl   = 1'b0;
                        n.dir_lvl  = 1'b0;
                        r.tx_valid = 1'b1;
                        if (s.cmd_cnt == HEADER_SLOT)
                            r.tx_word = READ_HEADER | (WORD_W'(s.addr) << ADDR_SHIFT);
                        else
                            r.tx_word = SYNC_SEQ[s.cmd_cnt];
                        n.cmd_cnt = s.cmd_cnt + 1'b1;
                    end else begin
                        n.cs_lvl  = 1'b1;
                        n.dir_lvl = 1'b0;
                        n.phase   = PH_TO_READ;
                    end
                end
                PH_TO_READ: begin
                    n.cs_lvl  = 1'b1;
                    n.dir_lvl = 1'b1;
                    n.phase   = PH_READ;
                end
                PH_READ: begin
                    n.cs_lvl  = 1'b0;
                    n.dir_lvl = 1'b1;
                    if (it.rx_valid) begin
                        junk = (it.rx_word == '0) || (it.rx_word == JUNK_D9) ||
                               (it.rx_word == JUNK_DB);
                        r.rx_accept = 1'b1;
                        cnt = (s.rx_cnt < RX_SAT) ? s.rx_cnt + 1'b1 : s.rx_cnt;
                        n.rx_cnt = cnt;
                        if (!(junk && cnt <= SKIP_LIMIT)) begin
                            r.reg_valid = 1'b1;
                            r.reg_value = it.rx_word;
                            n.phase     = PH_TO_WRITE;
                        end
                    end
                end
                PH_TO_WRITE: begin
                    n.cs_lvl  = 1'b1;
                    n.dir_lvl = 1'b1;
                    n.phase   = PH_DESYNC;
                end
                PH_DESYNC: begin
                    if (s.dsy_cnt < DSY_WORDS) begin
                        n.cs_lvl   = 1'b0;
                        n.dir_lvl  = 1'b0;
                        r.tx_valid = 1'b1;
                        r.tx_word  = DESYNC_SEQ[s.dsy_cnt[1:0]];
                        n.dsy_cnt  = s.dsy_cnt + 1'b1;
                    end else begin
                        n.cs_lvl   = 1'b1;
                        n.dir_lvl  = 1'b1;
                        n.phase    = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                default: n.phase = PH_IDLE;
            endcase
        end
        r.chip_select_n  = n.cs_lvl;
        r.read_not_write = n.dir_lvl;
    endfunction

    // append an item and advance the planning copy
    task automatic queue_item(input logic [INDEX_W-1:0] idx, input logic rxv,
                              input logic [WORD_W-1:0] word, input bit drain);
        t_step_item it;
        t_result    unused;
        if (pend_q.size() % 80 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
        it.reg_index   = idx;
        it.rx_valid    = rxv;
        it.rx_word     = word;
        it.gap         = tx_calm ? 0 : $urandom_range(0, 6);
        it.drain_first = drain;
        step_readback(plan_st, it, plan_st, unused);
        pend_q.push_back(it);
    endtask

    // stimulus and end of run
    initial begin
        logic [INDEX_W-1:0] idx;
        logic               rxv;
        logic [WORD_W-1:0]  word;
        int unsigned        junk_pct;
        plan_st  = reset_state();
        seq_st   = reset_state();
        junk_pct = 0;

        // rejected requests while idle: out of range and write-only
        queue_item(5'd20, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(5'd31, 1'b0, 32'h0, 1'b0);
        queue_item(5'd2, 1'b1, 32'h0, 1'b0);
        queue_item(5'd8, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_item(5'd10, 1'b1, 32'h0, 1'b0);
        queue_item(5'd11, 1'b0, 32'h0, 1'b0);
        // full readback of the highest address, index changes ignored mid-run
        queue_item(5'd19, 1'b0, 32'h0, 1'b0);
        for (int k = 0; k < 10; k++)
            queue_item((k == 4) ? 5'd0 : 5'd1, 1'b0, 32'h0, 1'b0);
        queue_item(5'd31, 1'b1, 32'h0, 1'b0);    // rejected inside the sequence
        queue_item(5'd0, 1'b1, 32'h0, 1'b0);     // turn to read
        queue_item(5'd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        // five skipped words, then a junk word taken as the sixth
        queue_item(5'd0, 1'b1, 32'h0, 1'b0);
        queue_item(5'd0, 1'b1, JUNK_D9, 1'b0);
        queue_item(5'd0, 1'b1, JUNK_DB, 1'b0);
        queue_item(5'd0, 1'b1, 32'h0, 1'b0);
        queue_item(5'd0, 1'b1, JUNK_DB, 1'b0);
        queue_item(5'd0, 1'b1, JUNK_D9, 1'b0);
        for (int k = 0; k < 6; k++)
            queue_item(5'd0, 1'b0, 32'h0, 1'b0);

        // random part: mostly well-formed sequences with random port traffic
        while (pend_q.size() < NUM_ITEMS) begin
            if (plan_st.phase == PH_IDLE)
                junk_pct = $urandom_range(0, 4) * 25;
            if ($urandom_range(0, 99) < 8) begin
                idx = INDEX_W'($urandom_range(0, 31));
            end else begin
                do idx = INDEX_W'($urandom_range(0, 19)); while (WRITE_ONLY[idx]);
            end
            if (plan_st.phase == PH_READ) begin
                rxv = ($urandom_range(0, 99) < 70);
                if ($urandom_range(0, 99) < junk_pct) begin
                    case ($urandom_range(0, 2))
                        0:       word = '0;
                        1:       word = JUNK_D9;
                        default: word = JUNK_DB;
                    endcase
                end else if ($urandom_range(0, 9) == 0) begin
                    word = '1;
                end else begin
                    word = $urandom;
                end
            end else begin
                rxv  = 1'($urandom_range(0, 1));
                word = $urandom;
            end
            queue_item(idx, rxv, word, pend_q.size() == DRAIN_AT);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d transfers: %0d register reads, %0d rejected requests,",
                 sent_cnt, read_cnt, reject_cnt);
        $display("%0d dropped port words, %0d result mismatches", drop_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // driver: present queued items, predict each accepted transfer
    always @(posedge i_clk) begin : drive
        t_result want;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                step_readback(seq_st, pend_q[0], seq_st, want);
                expect_q.push_back(want);
                sent_cnt++;
                if (want.reg_valid)
                    read_cnt++;
                if (want.rx_accept && !want.reg_valid)
                    drop_cnt++;
                if (!is_readable(pend_q[0].reg_index))
                    reject_cnt++;
                void'(pend_q.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (pend_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pend_q[0].drain_first && expect_q.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (pend_q[0].gap != 0) begin
                    pend_q[0].gap--;
                    i_valid <= 1'b0;
                end else begin
                    i_valid     <= 1'b1;
                    i_reg_index <= pend_q[0].reg_index;
                    i_rx_valid  <= pend_q[0].rx_valid;
                    i_rx_word   <= pend_q[0].rx_word;
                end
            end
        end
    end

    // monitor: compare results and draw the receiver's stalls
    always @(posedge i_clk) begin : monitor
        t_result     got;
        t_result     want;
        int unsigned stall_nxt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_nxt = (stall_left != 0) ? stall_left - 1 : 0;
            if (o_valid && !i_stall) begin
                got = '{o_chip_select_n, o_read_not_write, o_tx_valid, o_tx_word,
                        o_rx_accept, o_reg_valid, o_reg_value, o_done_res};
                if (expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result transfer: %p", got);
                end else begin
                    want = expect_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch at result %0d (cs_n rnw txv tx acc rv val done)",
                                     res_cnt);
                            $display("  expected %b %b %b %h %b %b %h %b",
                                     want.chip_select_n, want.read_not_write, want.tx_valid,
                                     want.tx_word, want.rx_accept, want.reg_valid,
                                     want.reg_value, want.done_res);
                            $display("  actual   %b %b %b %h %b %b %h %b",
                                     got.chip_select_n, got.read_not_write, got.tx_valid,
                                     got.tx_word, got.rx_accept, got.reg_valid,
                                     got.reg_value, got.done_res);
                        end
                    end
                end
                if (res_cnt % 64 == 63)
                    rx_calm <= ($urandom_range(0, 2) == 0);
                if (res_cnt == HOLD_AT)
                    stall_nxt = LONG_HOLD;   // long hold-off so the input backs up
                else
                    stall_nxt = rx_calm ? 0 : $urandom_range(0, 6);
                res_cnt++;
            end
            stall_left <= stall_nxt;
            i_stall    <= (stall_nxt != 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// ===== config_port_register_readback_sequencer_top.f =====
sv/cprs_pkg.sv
sv/cprs_step.sv
sv/config_port_register_readback_sequencer_top.sv
tb/tb.sv
